>>> sv/hopmai_pkg.sv
// Shared constants, register indexes and the hopping table for the allocation index generator.
package hopmai_pkg;

	// Largest mobile allocation the block supports; bigger sizes saturate to it.
	localparam logic [6:0] MAX_ALLOC = 7'd64;

	// Length of the pseudo-random hopping table.
	localparam logic [6:0] TABLE_LEN = 7'd114;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ALLOC_OFFSET = 2'd0;
	localparam logic [1:0] CFG_HOP_SEQ_NUM  = 2'd1;
	localparam logic [1:0] CFG_ALLOC_SIZE   = 2'd2;

	// Fixed 114-entry hopping table; indexes past the end never occur.
	function automatic logic [6:0] hop_table(input logic [6:0] idx);
		logic [6:0] v;
		case (idx)
			7'd0:   v = 7'd48;  7'd1:   v = 7'd98;  7'd2:   v = 7'd63;  7'd3:   v = 7'd1;
			7'd4:   v = 7'd36;  7'd5:   v = 7'd95;  7'd6:   v = 7'd78;  7'd7:   v = 7'd102;
			7'd8:   v = 7'd94;  7'd9:   v = 7'd73;  7'd10:  v = 7'd0;   7'd11:  v = 7'd64;
			7'd12:  v = 7'd25;  7'd13:  v = 7'd81;  7'd14:  v = 7'd76;  7'd15:  v = 7'd59;
			7'd16:  v = 7'd124; 7'd17:  v = 7'd23;  7'd18:  v = 7'd104; 7'd19:  v = 7'd100;
			7'd20:  v = 7'd101; 7'd21:  v = 7'd47;  7'd22:  v = 7'd118; 7'd23:  v = 7'd85;
			7'd24:  v = 7'd18;  7'd25:  v = 7'd56;  7'd26:  v = 7'd96;  7'd27:  v = 7'd86;
			7'd28:  v = 7'd54;  7'd29:  v = 7'd2;   7'd30:  v = 7'd80;  7'd31:  v = 7'd34;
			7'd32:  v = 7'd127; 7'd33:  v = 7'd13;  7'd34:  v = 7'd6;   7'd35:  v = 7'd89;
			7'd36:  v = 7'd57;  7'd37:  v = 7'd103; 7'd38:  v = 7'd12;  7'd39:  v = 7'd74;
			7'd40:  v = 7'd55;  7'd41:  v = 7'd111; 7'd42:  v = 7'd75;  7'd43:  v = 7'd38;
			7'd44:  v = 7'd109; 7'd45:  v = 7'd71;  7'd46:  v = 7'd112; 7'd47:  v = 7'd29;
			7'd48:  v = 7'd11;  7'd49:  v = 7'd88;  7'd50:  v = 7'd87;  7'd51:  v = 7'd19;
			7'd52:  v = 7'd3;   7'd53:  v = 7'd68;  7'd54:  v = 7'd110; 7'd55:  v = 7'd26;
			7'd56:  v = 7'd33;  7'd57:  v = 7'd31;  7'd58:  v = 7'd8;   7'd59:  v = 7'd45;
			7'd60:  v = 7'd82;  7'd61:  v = 7'd58;  7'd62:  v = 7'd40;  7'd63:  v = 7'd107;
			7'd64:  v = 7'd32;  7'd65:  v = 7'd5;   7'd66:  v = 7'd106; 7'd67:  v = 7'd92;
			7'd68:  v = 7'd62;  7'd69:  v = 7'd67;  7'd70:  v = 7'd77;  7'd71:  v = 7'd108;
			7'd72:  v = 7'd122; 7'd73:  v = 7'd37;  7'd74:  v = 7'd60;  7'd75:  v = 7'd66;
			7'd76:  v = 7'd121; 7'd77:  v = 7'd42;  7'd78:  v = 7'd51;  7'd79:  v = 7'd126;
			7'd80:  v = 7'd117; 7'd81:  v = 7'd114; 7'd82:  v = 7'd4;   7'd83:  v = 7'd90;
			7'd84:  v = 7'd43;  7'd85:  v = 7'd52;  7'd86:  v = 7'd53;  7'd87:  v = 7'd113;
			7'd88:  v = 7'd120; 7'd89:  v = 7'd72;  7'd90:  v = 7'd16;  7'd91:  v = 7'd49;
			7'd92:  v = 7'd7;   7'd93:  v = 7'd79;  7'd94:  v = 7'd119; 7'd95:  v = 7'd61;
			7'd96:  v = 7'd22;  7'd97:  v = 7'd84;  7'd98:  v = 7'd9;   7'd99:  v = 7'd97;
			7'd100: v = 7'd91;  7'd101: v = 7'd15;  7'd102: v = 7'd21;  7'd103: v = 7'd24;
			7'd104: v = 7'd46;  7'd105: v = 7'd39;  7'd106: v = 7'd93;  7'd107: v = 7'd105;
			7'd108: v = 7'd65;  7'd109: v = 7'd70;  7'd110: v = 7'd125; 7'd111: v = 7'd99;
			7'd112: v = 7'd17;  7'd113: v = 7'd123;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

	// One step of restoring remainder: shift in one dividend bit and subtract once if needed.
	function automatic logic [5:0] mod_step(input logic [5:0] rem, input logic din,
			input logic [6:0] n);
		logic [6:0] t;
		t = {rem, din};
		if (t >= n) begin
			t = t - n;
		end
		return t[5:0];
	endfunction

endpackage

>>> sv/hopping_mobile_allocation_index.sv
// Top level of the slow frequency hopping mobile allocation index generator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | request   | in_valid/in_stall  | frame_number, t1_part, t2_part, t3_part
//  out     | result    | out_valid/out_stall| alloc_index
//  cfg     | write     | cfg_we             | cfg_idx, cfg_wdata
//
// Seven register stages: table index, table lookup, folding and offset add, then four stages
// of a restoring remainder unit that retire six, six, six and five dividend bits. One request
// can enter every cycle while in_stall is low.
// Reset clears the valid bits and sets the registers to offset 0, sequence 0, size 1.
// Each stage holds while its successor is full and held; in_stall rises only when every
// stage up to the output register is occupied and out_stall is high.
module hopping_mobile_allocation_index (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [21:0] frame_number,
	input  logic [10:0] t1_part,
	input  logic [4:0]  t2_part,
	input  logic [5:0]  t3_part,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  alloc_index
);
	import hopmai_pkg::*;

	logic [5:0] alloc_offset_q;
	logic [5:0] hop_seq_q;
	logic [6:0] alloc_size_q;

	logic [6:0] size_n;
	logic [6:0] size_mask;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	logic [21:0] fn_s1, fn_s2;
	logic [6:0]  idx_s1;
	logic [4:0]  t2_s1;
	logic [5:0]  t3_s1, t3_s2;
	logic [7:0]  m_s2;
	logic [22:0] acc_s3;
	logic [16:0] acc_s4;
	logic [10:0] acc_s5;
	logic [4:0]  acc_s6;
	logic [5:0]  rem_s4, rem_s5, rem_s6, rem_s7;

	logic [6:0]  idx_raw;
	logic [6:0]  idx_wrap;
	logic [7:0]  m_next;
	logic [6:0]  mp;
	logic [6:0]  tp;
	logic [7:0]  fold;
	logic [21:0] x_val;
	logic [22:0] acc_next;
	logic [5:0]  rem4_next, rem5_next, rem6_next, rem7_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_offset_q <= 6'd0;
			hop_seq_q      <= 6'd0;
			alloc_size_q   <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ALLOC_OFFSET: alloc_offset_q <= cfg_wdata[5:0];
				CFG_HOP_SEQ_NUM:  hop_seq_q      <= cfg_wdata[5:0];
				CFG_ALLOC_SIZE:   alloc_size_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective allocation size and the all-ones mask of its bit length.
	always_comb begin
		if (alloc_size_q == 7'd0) begin
			size_n = 7'd1;
		end else if (alloc_size_q > MAX_ALLOC) begin
			size_n = MAX_ALLOC;
		end else begin
			size_n = alloc_size_q;
		end
		size_mask = size_n | (size_n >> 1) | (size_n >> 2) | (size_n >> 3)
			| (size_n >> 4) | (size_n >> 5) | (size_n >> 6);
	end

	// A stage may load when it is empty or its contents move on in the same cycle.
	assign en_s7 = !v_s7 || !out_stall;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Stage 1: table index, wrapped once past the end of the table.
	always_comb begin
		idx_raw = {1'b0, hop_seq_q ^ t1_part[5:0]} + {1'b0, t3_part};
		if (idx_raw >= TABLE_LEN) begin
			idx_wrap = idx_raw - TABLE_LEN;
		end else begin
			idx_wrap = idx_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			fn_s1  <= frame_number;
			idx_s1 <= idx_wrap;
			t2_s1  <= t2_part;
			t3_s1  <= t3_part;
		end
	end

	// Stage 2: table lookup plus T2.
	assign m_next = {3'b000, t2_s1} + {1'b0, hop_table(idx_s1)};

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			fn_s2 <= fn_s1;
			m_s2  <= m_next;
			t3_s2 <= t3_s1;
		end
	end

	// Stage 3: fold an out-of-range value with T3, add the offset; sequence 0 uses fn_s2.
	// Both masked terms are below twice the size, so their sum needs at most three subtractions.
	always_comb begin
		mp   = m_s2[6:0] & size_mask;
		tp   = {1'b0, t3_s2} & size_mask;
		fold = {1'b0, mp};
		if (mp >= size_n) begin
			fold = {1'b0, mp} + {1'b0, tp};
			if (fold >= {1'b0, size_n}) fold = fold - {1'b0, size_n};
			if (fold >= {1'b0, size_n}) fold = fold - {1'b0, size_n};
			if (fold >= {1'b0, size_n}) fold = fold - {1'b0, size_n};
		end
		if (hop_seq_q == 6'd0) begin
			x_val = fn_s2;
		end else begin
			x_val = {16'd0, fold[5:0]};
		end
		acc_next = {1'b0, x_val} + {17'd0, alloc_offset_q};
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			acc_s3 <= acc_next;
		end
	end

	// Stages 4 to 7: remainder by the allocation size, most significant bits first.
	always_comb begin
		rem4_next = 6'd0;
		for (int i = 22; i >= 17; i--) begin
			rem4_next = mod_step(rem4_next, acc_s3[i], size_n);
		end
		rem5_next = rem_s4;
		for (int i = 16; i >= 11; i--) begin
			rem5_next = mod_step(rem5_next, acc_s4[i], size_n);
		end
		rem6_next = rem_s5;
		for (int i = 10; i >= 5; i--) begin
			rem6_next = mod_step(rem6_next, acc_s5[i], size_n);
		end
		rem7_next = rem_s6;
		for (int i = 4; i >= 0; i--) begin
			rem7_next = mod_step(rem7_next, acc_s6[i], size_n);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			rem_s4 <= rem4_next;
			acc_s4 <= acc_s3[16:0];
		end
		if (en_s5 && v_s4) begin
			rem_s5 <= rem5_next;
			acc_s5 <= acc_s4[10:0];
		end
		if (en_s6 && v_s5) begin
			rem_s6 <= rem6_next;
			acc_s6 <= acc_s5[4:0];
		end
		if (en_s7 && v_s6) begin
			rem_s7 <= rem7_next;
		end
	end

	assign out_valid   = v_s7;
	assign alloc_index = rem_s7;

	// The table index has always been wrapped into the table.
	a_idx_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> idx_s1 < TABLE_LEN)
		else $error("table index past the end of the hopping table");

	// Partial remainders stay below the allocation size.
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> {1'b0, rem_s4} < size_n)
		else $error("partial remainder not below the allocation size");

	// Every delivered index lies inside the mobile allocation.
	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, alloc_index} < size_n)
		else $error("allocation index not below the allocation size");

	// Requests are held off only when the whole pipeline is full behind a held result.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && out_stall))
		else $error("input held off while the pipeline has room");

endmodule

>>> test/hopping_mobile_allocation_index_tb.sv
// Self-checking testbench for the hopping mobile allocation index generator.
module hopping_mobile_allocation_index_tb;
	import hopmai_pkg::*;

	// The fourth register index selects nothing and must leave the settings alone.
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 14;
	localparam int FN_LAST = 2715647;

	typedef struct packed {
		logic [21:0] fn;
		logic [10:0] t1;
		logic [4:0]  t2;
		logic [5:0]  t3;
	} tdma_frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [6:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [21:0] frame_number = '0;
	logic [10:0] t1_part = '0;
	logic [4:0]  t2_part = '0;
	logic [5:0]  t3_part = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  alloc_index;

	// Shadow copy of the configuration registers.
	logic [5:0] cur_offset = '0;
	logic [5:0] cur_hsn = '0;
	logic [6:0] cur_size = 7'd1;

	logic [5:0] expected_mai[$];
	logic [5:0] oldest_mai;
	int         errors = 0;
	bit         sender_gaps = 1'b0;
	bit         receiver_gaps = 1'b0;
	int         long_hold_req = 0;
	int         hold_left = 0;
	int         burst_left = 0;

	bit [6:0] hop_values [0:113] = '{
		48, 98, 63, 1, 36, 95, 78, 102, 94, 73,
		0, 64, 25, 81, 76, 59, 124, 23, 104, 100,
		101, 47, 118, 85, 18, 56, 96, 86, 54, 2,
		80, 34, 127, 13, 6, 89, 57, 103, 12, 74,
		55, 111, 75, 38, 109, 71, 112, 29, 11, 88,
		87, 19, 3, 68, 110, 26, 33, 31, 8, 45,
		82, 58, 40, 107, 32, 5, 106, 92, 62, 67,
		77, 108, 122, 37, 60, 66, 121, 42, 51, 126,
		117, 114, 4, 90, 43, 52, 53, 113, 120, 72,
		16, 49, 7, 79, 119, 61, 22, 84, 9, 97,
		91, 15, 21, 24, 46, 39, 93, 105, 65, 70,
		125, 99, 17, 123
	};

	hopping_mobile_allocation_index dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_number(frame_number),
		.t1_part(t1_part),
		.t2_part(t2_part),
		.t3_part(t3_part),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.alloc_index(alloc_index)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [5:0] predict_mai(input tdma_frame_t f);
		int unsigned n;
		int unsigned nbin;
		int unsigned mask;
		int unsigned idx;
		int unsigned mp;
		int unsigned s;
		n = cur_size;
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_ALLOC) begin
			n = MAX_ALLOC;
		end
		if (cur_hsn == 0) begin
			return 6'((f.fn + cur_offset) % n);
		end
		nbin = 0;
		for (int b = 0; b < 8; b++) begin
			if ((n >> b) != 0) begin
				nbin = b + 1;
			end
		end
		mask = (1 << nbin) - 1;
		idx = (cur_hsn ^ f.t1[5:0]) + f.t3;
		// The table index can run past the end when T3 is out of range; it wraps round.
		if (idx >= 114) begin
			idx = idx - 114;
		end
		mp = (f.t2 + hop_values[idx]) & mask;
		if (mp < n) begin
			s = mp;
		end else begin
			s = (mp + (f.t3 & mask)) % n;
		end
		return 6'((s + cur_offset) % n);
	endfunction

	// Records each accepted request and configuration write, and checks each result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_mai.push_back(predict_mai({frame_number, t1_part, t2_part, t3_part}));
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ALLOC_OFFSET: cur_offset = cfg_wdata[5:0];
					CFG_HOP_SEQ_NUM: cur_hsn = cfg_wdata[5:0];
					CFG_ALLOC_SIZE: cur_size = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_mai.size() == 0) begin
					$error("alloc_index: expected nothing, got %0d", alloc_index);
					errors++;
				end else begin
					oldest_mai = expected_mai.pop_front();
					if (alloc_index !== oldest_mai) begin
						$error("alloc_index: expected %0d, got %0d", oldest_mai, alloc_index);
						errors++;
					end
				end
			end
		end
	end

	// Receiver: a long hold when one is asked for, otherwise random stall bursts while receiver_gaps is set.
	always @(negedge clk) begin
		if (long_hold_req > 0) begin
			hold_left = long_hold_req;
			long_hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (burst_left > 0) begin
			out_stall <= 1'b1;
			burst_left--;
		end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			burst_left = $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic tdma_frame_t make_frame(input int unsigned fn);
		tdma_frame_t f;
		f.fn = 22'(fn);
		f.t1 = 11'(fn / 1326);
		f.t2 = 5'(fn % 26);
		f.t3 = 6'(fn % 51);
		return f;
	endfunction

	function automatic tdma_frame_t noise_frame();
		tdma_frame_t f;
		f.fn = 22'($urandom);
		f.t1 = 11'($urandom);
		f.t2 = 5'($urandom);
		f.t3 = 6'($urandom);
		return f;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input tdma_frame_t f);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		frame_number <= f.fn;
		t1_part <= f.t1;
		t2_part <= f.t2;
		t3_part <= f.t3;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_mai.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [6:0] offset, input logic [6:0] hsn,
			input logic [6:0] size);
		write_reg(CFG_ALLOC_OFFSET, offset);
		write_reg(CFG_HOP_SEQ_NUM, hsn);
		write_reg(CFG_ALLOC_SIZE, size);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_settings();
		send_request(make_frame(0));
		send_request(make_frame(FN_LAST));
		send_request({22'h3FFFFF, 11'h7FF, 5'h1F, 6'h3F});
		wait_drained();
	endtask

	task automatic test_cyclic();
		set_config(7'd63, 7'd0, 7'd64);
		send_request(make_frame(0));
		send_request(make_frame(FN_LAST));
		send_request({22'h3FFFFF, 11'h000, 5'h00, 6'h00});
		wait_drained();
		set_config(7'd127, 7'd64, 7'd37);
		send_request(make_frame(1234567));
		send_request(make_frame(36));
		wait_drained();
	endtask

	task automatic test_size_limits();
		// A size of zero behaves as one, and sizes above the maximum saturate.
		set_config(7'd17, 7'd9, 7'd0);
		send_request(make_frame(98765));
		send_request(make_frame(0));
		wait_drained();
		set_config(7'd5, 7'd0, 7'd127);
		send_request(make_frame(FN_LAST));
		wait_drained();
		write_reg(CFG_ALLOC_OFFSET, 7'd40);
		write_reg(CFG_HOP_SEQ_NUM, 7'd33);
		write_reg(CFG_ALLOC_SIZE, 7'd65);
		write_reg(CFG_SPARE, 7'h7F);
		cfg_we <= 1'b0;
		send_request(make_frame(555555));
		send_request({22'h2AAAAA, 11'h555, 5'h1F, 6'h3F});
		wait_drained();
	endtask

	task automatic test_hopping();
		set_config(7'd0, 7'd63, 7'd64);
		// T3 above range pushes the table index past the end in both of these.
		send_request({22'd0, 11'd0, 5'd31, 6'd63});
		send_request({22'd0, 11'd0, 5'd0, 6'd51});
		send_request({22'd0, 11'd63, 5'd0, 6'd0});
		send_request({22'd0, 11'd2047, 5'd25, 6'd50});
		send_request(make_frame(FN_LAST));
		wait_drained();
		set_config(7'd2, 7'd5, 7'd3);
		for (int i = 0; i < 4; i++) begin
			send_request(make_frame(2000 + i));
		end
		wait_drained();
		set_config(7'd63, 7'd1, 7'd1);
		send_request(make_frame(777));
		wait_drained();
	endtask

	task automatic test_backpressure();
		int unsigned fn;
		set_config(7'd11, 7'd42, 7'd47);
		fn = $urandom_range(0, FN_LAST - 40);
		long_hold_req = 80;
		for (int i = 0; i < 30; i++) begin
			send_request(make_frame(fn + i));
		end
		wait_drained();
	endtask

	task automatic test_random();
		int unsigned fn;
		logic [6:0]  size;
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 0) begin
				set_config(7'd63, 7'd63, 7'd64);
			end else if (phase == 1) begin
				set_config(7'd0, 7'd1, 7'd2);
			end else begin
				case ($urandom_range(0, 9))
					0: size = 7'd0;
					1: size = 7'($urandom_range(65, 127));
					default: size = 7'($urandom_range(1, 64));
				endcase
				set_config(7'($urandom_range(0, 127)),
					($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 127)), size);
			end
			sender_gaps = (phase < 8) && ($urandom_range(0, 3) != 0);
			receiver_gaps = (phase < 8) && ($urandom_range(0, 3) != 0);
			fn = $urandom_range(0, FN_LAST);
			for (int i = 0; i < 44; i++) begin
				if ($urandom_range(0, 5) == 0) begin
					send_request(noise_frame());
				end else begin
					if ($urandom_range(0, 3) == 0 || fn >= FN_LAST) begin
						fn = $urandom_range(0, FN_LAST);
					end else begin
						fn++;
					end
					send_request(make_frame(fn));
				end
			end
			wait_drained();
		end
	endtask

	initial begin
		#5000000;
		$display("hopping_mobile_allocation_index_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		test_reset_settings();
		test_cyclic();
		test_size_limits();
		test_hopping();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		test_backpressure();
		test_random();
		if (errors == 0) begin
			$display("hopping_mobile_allocation_index_tb OK");
		end else begin
			$display("hopping_mobile_allocation_index_tb NOT OK");
		end
		$finish;
	end

endmodule
